// ===== design/assert_macros.svh =====
// assertion macros included by the slab test module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RBST_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rbst assertion failed");

// condition that must never be seen outside reset
`define RBST_NEVER(label, cond) \
  `RBST_ASSERT(label, !(cond))

`endif

// ===== design/rbst_pkg.sv =====
// shared widths, codes and divider handshake types of the slab test
`default_nettype none
package rbst_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 16;
  localparam int DIFF_W  = COORD_W + 1;
  // quotient bits produced by the serial divider once saturation is ruled out
  localparam int DIV_STEPS = COORD_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  // numerator bits shifted in below the first partial remainder
  localparam int LOW_W     = COORD_W - 1 - FRAC_W;

  localparam logic [CFG_W-1:0] MIN_ABS_DIR_RST = CFG_W'(1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_X     = 2'd0;
  localparam axis_t AXIS_Z     = 2'd2;
  localparam axis_t AXIS_SPARE = 2'd3;

  typedef struct packed {
    logic                start;
    logic                neg;
    logic [DIFF_W-1:0]   num;
    logic [COORD_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic   done;
    logic   busy;
    coord_t quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/rbst_if.sv =====
// channel interfaces: axis word in, hit word out, config write
`default_nettype none
interface rbst_in_if;
  logic                   valid;
  logic                   ready;
  rbst_pkg::coord_t       slab_min;
  rbst_pkg::coord_t       slab_max;
  rbst_pkg::coord_t       ray_origin;
  rbst_pkg::coord_t       ray_dir;
  rbst_pkg::coord_t       range_min;
  rbst_pkg::coord_t       range_max;

  modport source (output valid, slab_min, slab_max, ray_origin, ray_dir,
                  range_min, range_max, input ready);
  modport sink   (input valid, slab_min, slab_max, ray_origin, ray_dir,
                  range_min, range_max, output ready);
endinterface

interface rbst_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

interface rbst_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rbst_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/rbst_div.sv =====
// serial radix-2 divider: saturated signed (num << frac) / den
`default_nettype none
module rbst_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rbst_pkg::div_req_t req_i,
  output rbst_pkg::div_rsp_t      rsp_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_SAT,
    D_STEP,
    D_DONE
  } dstate_e;

  dstate_e                                dstate_q;
  logic [rbst_pkg::COORD_W-1:0]           rem_q;
  logic [rbst_pkg::COORD_W-1:0]           den_q;
  logic [rbst_pkg::DIV_STEPS-1:0]         bits_q;
  logic [rbst_pkg::DIV_STEPS-1:0]         quo_q;
  logic [rbst_pkg::DIV_CNT_W-1:0]         cnt_q;
  logic                                   neg_q;
  logic                                   sat_q;
  logic                                   done_q;
  rbst_pkg::coord_t                       quot_q;

  logic [rbst_pkg::COORD_W:0]             rem2;
  logic [rbst_pkg::COORD_W+1:0]           trial;
  logic                                   fits;

  // shift in the next numerator bit and try the subtract
  assign rem2  = {rem_q, bits_q[rbst_pkg::DIV_STEPS-1]};
  assign trial = {1'b0, rem2} - {2'b00, den_q};
  assign fits  = !trial[rbst_pkg::COORD_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q <= D_IDLE;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (dstate_q)
        D_IDLE: begin
          if (req_i.start) begin
            rem_q    <= rbst_pkg::COORD_W'(req_i.num[rbst_pkg::DIFF_W-1:rbst_pkg::LOW_W]);
            bits_q   <= {req_i.num[rbst_pkg::LOW_W-1:0], {rbst_pkg::FRAC_W{1'b0}}};
            den_q    <= req_i.den;
            neg_q    <= req_i.neg;
            sat_q    <= 1'b0;
            cnt_q    <= '0;
            dstate_q <= D_SAT;
          end
        end
        D_SAT: begin
          // quotient at or above 2^(w-1) saturates
          if (rem_q >= den_q) begin
            sat_q    <= 1'b1;
            dstate_q <= D_DONE;
          end else begin
            dstate_q <= D_STEP;
          end
        end
        D_STEP: begin
          rem_q  <= fits ? trial[rbst_pkg::COORD_W-1:0] : rem2[rbst_pkg::COORD_W-1:0];
          quo_q  <= {quo_q[rbst_pkg::DIV_STEPS-2:0], fits};
          bits_q <= {bits_q[rbst_pkg::DIV_STEPS-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == rbst_pkg::DIV_CNT_W'(rbst_pkg::DIV_STEPS - 1)) begin
            dstate_q <= D_DONE;
          end
        end
        D_DONE: begin
          if (sat_q) begin
            quot_q <= neg_q ? {1'b1, {(rbst_pkg::COORD_W-1){1'b0}}}
                            : {1'b0, {(rbst_pkg::COORD_W-1){1'b1}}};
          end else begin
            quot_q <= neg_q ? (~{1'b0, quo_q} + 1'b1) : {1'b0, quo_q};
          end
          done_q   <= 1'b1;
          dstate_q <= D_IDLE;
        end
        default: dstate_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = (dstate_q != D_IDLE);
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

// ===== design/ray_box_slab_test.sv =====
// ray versus axis-aligned box slab test, three axis words per test
//
// channel    dir   port      payload
// item_i     in    sink      slab bounds, origin, direction, start range (x word)
// result_o   out   source    hit, one word per test after the z word
// cfg_i      in    sink      min_abs_direction, always ready
//
// an axis word runs two divider passes (start, saturation check, 31 quotient bits,
// sign fix, handoff; the quotient bits are skipped when the quotient saturates)
// between capture, checks, subtracts and narrowing; a word whose test has already
// missed or whose direction is too small skips the subtracts and divider passes
// item_i.ready is high only between words; a z word waits while a hit word is held
// async active-low reset returns to the x axis with the register at 1
`default_nettype none
module ray_box_slab_test (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rbst_in_if.sink    item_i,
  rbst_cfg_if.sink   cfg_i,
  rbst_out_if.source result_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SUB_LO,
    S_GO_LO,
    S_WAIT_LO,
    S_SUB_HI,
    S_GO_HI,
    S_WAIT_HI,
    S_ORDER,
    S_NARROW,
    S_TEST,
    S_FINISH
  } state_e;

  state_e                          state_q;
  rbst_pkg::axis_t                 axis_q;
  logic                            missed_q;
  logic [rbst_pkg::CFG_W-1:0]      min_abs_q;
  logic                            out_valid_q;
  logic                            hit_q;

  // captured axis word
  rbst_pkg::coord_t                lo_q, hi_q, org_q, dir_q;
  // running parameter range and per-axis slab times
  rbst_pkg::coord_t                enter_q, exit_q;
  rbst_pkg::coord_t                t0_q, t1_q, tlo_q, thi_q;
  logic [rbst_pkg::COORD_W-1:0]    den_q;
  logic signed [rbst_pkg::DIFF_W-1:0] sdiff_q;

  logic [rbst_pkg::COORD_W-1:0]    dir_mag;
  logic                            parallel;
  logic                            first_axis;
  logic                            last_axis;
  logic                            accept;
  logic                            out_stall;

  rbst_pkg::div_req_t              div_req;
  rbst_pkg::div_rsp_t              div_rsp;

  assign item_i.ready    = (state_q == S_IDLE);
  assign accept          = item_i.valid && item_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign result_o.valid  = out_valid_q;
  assign result_o.hit    = hit_q;

  // an axis index of three restarts a test like the x axis
  assign first_axis = (axis_q == rbst_pkg::AXIS_X) || (axis_q == rbst_pkg::AXIS_SPARE);
  assign last_axis  = (axis_q == rbst_pkg::AXIS_Z);
  assign out_stall  = last_axis && out_valid_q && !result_o.ready;

  // direction magnitude; the most negative value maps to 2^(w-1)
  assign dir_mag  = dir_q[rbst_pkg::COORD_W-1] ? (~dir_q + 1'b1) : dir_q;
  assign parallel = (dir_q == '0) ||
                    (dir_mag < rbst_pkg::COORD_W'(min_abs_q));

  // divider request: magnitude of (bound - origin) over |dir|, sign applied after
  always_comb begin
    div_req.start = (state_q == S_GO_LO) || (state_q == S_GO_HI);
    div_req.neg   = sdiff_q[rbst_pkg::DIFF_W-1] ^ dir_q[rbst_pkg::COORD_W-1];
    div_req.num   = sdiff_q[rbst_pkg::DIFF_W-1] ? (~sdiff_q + 1'b1) : sdiff_q;
    div_req.den   = den_q;
  end

  rbst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= rbst_pkg::AXIS_X;
      missed_q    <= 1'b0;
      min_abs_q   <= rbst_pkg::MIN_ABS_DIR_RST;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      enter_q     <= '0;
      exit_q      <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        min_abs_q <= cfg_i.data;
      end
      if (result_o.valid && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            lo_q  <= item_i.slab_min;
            hi_q  <= item_i.slab_max;
            org_q <= item_i.ray_origin;
            dir_q <= item_i.ray_dir;
            if (first_axis) begin
              axis_q   <= rbst_pkg::AXIS_X;
              enter_q  <= item_i.range_min;
              exit_q   <= item_i.range_max;
              missed_q <= 1'b0;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          den_q <= dir_mag;
          if (missed_q) begin
            state_q <= S_FINISH;
          end else if (parallel) begin
            missed_q <= 1'b1;
            state_q  <= S_FINISH;
          end else begin
            state_q <= S_SUB_LO;
          end
        end
        S_SUB_LO: begin
          sdiff_q <= {lo_q[rbst_pkg::COORD_W-1], lo_q} - {org_q[rbst_pkg::COORD_W-1], org_q};
          state_q <= S_GO_LO;
        end
        S_GO_LO: begin
          state_q <= S_WAIT_LO;
        end
        S_WAIT_LO: begin
          if (div_rsp.done) begin
            t0_q    <= div_rsp.quot;
            state_q <= S_SUB_HI;
          end
        end
        S_SUB_HI: begin
          sdiff_q <= {hi_q[rbst_pkg::COORD_W-1], hi_q} - {org_q[rbst_pkg::COORD_W-1], org_q};
          state_q <= S_GO_HI;
        end
        S_GO_HI: begin
          state_q <= S_WAIT_HI;
        end
        S_WAIT_HI: begin
          if (div_rsp.done) begin
            t1_q    <= div_rsp.quot;
            state_q <= S_ORDER;
          end
        end
        S_ORDER: begin
          // near and far slab crossings
          if (t0_q > t1_q) begin
            tlo_q <= t1_q;
            thi_q <= t0_q;
          end else begin
            tlo_q <= t0_q;
            thi_q <= t1_q;
          end
          state_q <= S_NARROW;
        end
        S_NARROW: begin
          if (tlo_q > enter_q) begin
            enter_q <= tlo_q;
          end
          if (thi_q < exit_q) begin
            exit_q <= thi_q;
          end
          state_q <= S_TEST;
        end
        S_TEST: begin
          // empty range, including a touching one, is a miss
          if (exit_q <= enter_q) begin
            missed_q <= 1'b1;
          end
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_stall) begin
            if (last_axis) begin
              out_valid_q <= 1'b1;
              hit_q       <= !missed_q;
              axis_q      <= rbst_pkg::AXIS_X;
            end else begin
              axis_q <= axis_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  // divider answers only while the sequencer waits for it
  `RBST_ASSERT(a_div_done_waited, div_rsp.done |-> (state_q == S_WAIT_LO || state_q == S_WAIT_HI))
  // no division is started for a test that has already missed, nor while the divider is busy
  `RBST_NEVER(a_no_div_after_miss, div_req.start && (missed_q || div_rsp.busy))
  // a fresh hit word always follows the last axis and rewinds the axis count
  `RBST_ASSERT(a_hit_after_z, $rose(out_valid_q) |-> (axis_q == rbst_pkg::AXIS_X && $past(last_axis)))
  // ordered crossings feed the narrowing step
  `RBST_ASSERT(a_ordered_pair, (state_q == S_NARROW) |-> (tlo_q <= thi_q))

endmodule
`default_nettype wire
